// ----- design/bcd_pkg.sv -----
// Shared constants and types for the bracket command deframer.
`default_nettype none
package bcd_pkg;

  // Frame store geometry
  localparam int BufferDepth = 64;
  localparam int AddrW       = $clog2(BufferDepth);
  localparam int CntW        = $clog2(BufferDepth + 1);

  // Framing characters
  localparam logic [7:0] ChOpenCmd  = 8'h3C;  // '<'
  localparam logic [7:0] ChOpenTag  = 8'h5B;  // '['
  localparam logic [7:0] ChQuote    = 8'h22;  // '"'
  localparam logic [7:0] ChCloseCmd = 8'h3E;  // '>'
  localparam logic [7:0] ChCloseTag = 8'h7E;  // '~'

  // Frame kinds
  localparam logic KindCmd = 1'b0;
  localparam logic KindTag = 1'b1;

  // One classified item passed from front to back
  typedef struct packed {
    logic       open;   // restart the store before this byte
    logic       store;  // append data to the store
    logic       close;  // replay the store after this byte
    logic       kind;   // frame kind for the replay
    logic [7:0] data;
  } bcd_op_t;

endpackage
`default_nettype wire

// ----- design/bcd_front.sv -----
// Front end: tracks the framer mode and classifies each received byte.
`default_nettype none
module bcd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [7:0]     s_tdata,
  output logic                push_valid,
  input  wire logic           push_ready,
  output bcd_pkg::bcd_op_t    push_op
);

  typedef enum logic [1:0] {
    MODE_WAITING,
    MODE_COMMAND,
    MODE_STRING,
    MODE_TAGGED
  } mode_t;

  mode_t mode, mode_next;
  logic  push;
  logic  accept;

  assign s_tready   = push_ready;
  assign accept     = s_tvalid && push_ready;
  assign push_valid = s_tvalid && push;

  // Classify the byte against the current mode
  always_comb begin
    mode_next     = mode;
    push          = 1'b0;
    push_op.open  = 1'b0;
    push_op.store = 1'b0;
    push_op.close = 1'b0;
    push_op.kind  = bcd_pkg::KindCmd;
    push_op.data  = s_tdata;
    unique case (mode)
      MODE_WAITING: begin
        if (s_tdata == bcd_pkg::ChOpenCmd) begin
          push          = 1'b1;
          push_op.open  = 1'b1;
          push_op.store = 1'b1;
          mode_next     = MODE_COMMAND;
        end else if (s_tdata == bcd_pkg::ChOpenTag) begin
          push          = 1'b1;
          push_op.open  = 1'b1;
          push_op.store = 1'b1;
          mode_next     = MODE_TAGGED;
        end
      end
      MODE_COMMAND: begin
        push          = 1'b1;
        push_op.store = 1'b1;
        if (s_tdata == bcd_pkg::ChQuote) begin
          mode_next = MODE_STRING;
        end else if (s_tdata == bcd_pkg::ChCloseCmd) begin
          push_op.close = 1'b1;
          push_op.kind  = bcd_pkg::KindCmd;
          mode_next     = MODE_WAITING;
        end
      end
      MODE_STRING: begin
        push          = 1'b1;
        push_op.store = 1'b1;
        if (s_tdata == bcd_pkg::ChQuote) begin
          mode_next = MODE_COMMAND;
        end
      end
      MODE_TAGGED: begin
        push = 1'b1;
        if (s_tdata == bcd_pkg::ChCloseTag) begin
          push_op.close = 1'b1;
          push_op.kind  = bcd_pkg::KindTag;
          mode_next     = MODE_WAITING;
        end else begin
          push_op.store = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_WAITING;
      end
    endcase
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_WAITING;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/bcd_queue.sv -----
// Two-entry queue of classified items between front and back.
`default_nettype none
module bcd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bcd_pkg::bcd_op_t  in_op,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bcd_pkg::bcd_op_t       out_op
);

  bcd_pkg::bcd_op_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_op    = entries[rd_ptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= in_op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/bcd_back.sv -----
// Back end: frame store, fill count and replay of a closed frame.
`default_nettype none
module bcd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              op_valid,
  output logic                   op_ready,
  input  wire bcd_pkg::bcd_op_t  op,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast,
  output logic                   m_tuser
);

  logic [7:0] mem [bcd_pkg::BufferDepth];

  logic [bcd_pkg::CntW-1:0] count;
  logic [bcd_pkg::CntW-1:0] cnt_base;
  logic [bcd_pkg::CntW-1:0] cnt_after;
  logic                     room;
  logic                     pop;
  logic                     wr_en;

  // Replay sequencer
  logic                     busy;
  logic [bcd_pkg::CntW-1:0] ptr;
  logic [bcd_pkg::CntW-1:0] len;
  logic                     rkind;
  logic                     issue;
  logic                     issue_last;

  // Read stage and output stage
  logic       s1_valid;
  logic [7:0] rd_data;
  logic       s1_last;
  logic       s1_kind;
  logic       can_adv;

  assign op_ready = !busy;
  assign pop      = op_valid && !busy;

  // Count update for the popped item
  always_comb begin
    cnt_base  = op.open ? '0 : count;
    room      = (cnt_base < bcd_pkg::CntW'(bcd_pkg::BufferDepth));
    wr_en     = pop && op.store && room;
    cnt_after = (op.store && room) ? cnt_base + 1'b1 : cnt_base;
  end

  assign can_adv    = !m_tvalid || m_tready;
  assign issue      = busy && (!s1_valid || can_adv);
  assign issue_last = (ptr + 1'b1 == len);

  // Frame store: write on store, registered read on replay
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_base[bcd_pkg::AddrW-1:0]] <= op.data;
    end
    if (issue) begin
      rd_data <= mem[ptr[bcd_pkg::AddrW-1:0]];
      s1_last <= issue_last;
      s1_kind <= rkind;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (can_adv) begin
      m_tdata <= rd_data;
      m_tlast <= s1_last;
      m_tuser <= s1_kind;
    end
  end

  // Control: fill count, replay pointer, stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      busy     <= 1'b0;
      ptr      <= '0;
      len      <= '0;
      rkind    <= bcd_pkg::KindCmd;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        count <= cnt_after;
        if (op.close) begin
          busy  <= 1'b1;
          ptr   <= '0;
          len   <= cnt_after;
          rkind <= op.kind;
        end
      end
      if (issue) begin
        ptr <= ptr + 1'b1;
        if (issue_last) begin
          busy <= 1'b0;
        end
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (can_adv) begin
        s1_valid <= 1'b0;
      end
      if (can_adv) begin
        m_tvalid <= s1_valid;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/bracket_command_deframer_unit.sv -----
// Top level of the bracket command deframer: front, queue and back.
// A closing byte passes the queue entry, the replay sequencer, the read stage and the
// output stage before its first frame byte leaves. Throughput: one received byte per
// cycle while no frame is replayed; a close replays the store at one byte per cycle
// while m_tready holds, during which the two-entry queue fills and then input stalls.
// Reset (rst, synchronous): mode to waiting, fill count zero, queue and output empty.
`default_nettype none
module bracket_command_deframer_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] frame_byte
  output logic            m_tlast,   // last_byte
  output logic            m_tuser    // [0] frame_kind
);

  logic             f_valid;
  logic             f_ready;
  bcd_pkg::bcd_op_t f_op;
  logic             b_valid;
  logic             b_ready;
  bcd_pkg::bcd_op_t b_op;

  bcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_op    (f_op)
  );

  bcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_op     (f_op),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_op    (b_op)
  );

  bcd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (b_valid),
    .op_ready (b_ready),
    .op       (b_op),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire
